// ===== src/idrs_pkg.sv =====
// Package for the identifier deduplicating ring store.
// Holds the store geometry, field widths, status codes and the memory request type.
// No dependencies.
`default_nettype none

package idrs_pkg;

    localparam int DEPTH    = 512;
    localparam int ID_BITS  = 16;

    localparam int LEN_W    = 7;
    localparam int IDENT_W  = 16;
    localparam int PTR_W    = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);

    // Only a payload exactly as long as one identifier is taken.
    localparam logic [LEN_W-1:0] LEN_OK = LEN_W'(ID_BITS / 8);

    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    typedef enum logic [1:0] {
        ST_STORED     = 2'd0,
        ST_DUPLICATE  = 2'd1,
        ST_BAD_LENGTH = 2'd2
    } status_t;

    typedef struct packed {
        logic               wr_en;
        logic [PTR_W-1:0]   wr_addr;
        logic [ID_BITS-1:0] wr_data;
        logic               rd_en;
        logic [PTR_W-1:0]   rd_addr;
    } ram_req_t;

endpackage

`default_nettype wire

// ===== src/idrs_if.sv =====
// Channel interfaces of the identifier deduplicating ring store.
// Depends on idrs_pkg for the field widths.
`default_nettype none

interface idrs_pkt_if
    import idrs_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [LEN_W-1:0]   packet_length;
    logic [IDENT_W-1:0] ident;

    modport source (output valid, output packet_length, output ident, input ready);
    modport sink   (input valid, input packet_length, input ident, output ready);
endinterface

interface idrs_res_if
    import idrs_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [1:0]       status;
    logic [CNT_W-1:0] fill_level;

    modport source (output valid, output status, output fill_level, input ready);
    modport sink   (input valid, input status, input fill_level, output ready);
endinterface

`default_nettype wire

// ===== src/idrs_ram.sv =====
// Identifier memory: one write port and one read port with registered read data.
// Depends on idrs_pkg for the geometry and the request type.
`default_nettype none

module idrs_ram
    import idrs_pkg::*;
(
    input  wire logic               clk,
    input  wire ram_req_t           req,
    output      logic [ID_BITS-1:0] rd_data
);

    logic [ID_BITS-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data <= mem[req.rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== src/identifier_dedup_ring_store.sv =====
// Top level of the identifier deduplicating ring store: sequencer, pointers and result register.
// Depends on idrs_pkg, idrs_if and idrs_ram.
//
//   channel | modport | payload                      | transaction
//   pkt     | sink    | packet_length[6:0], ident    | one received packet
//   result  | source  | status[1:0], fill_level[9:0] | one result per packet
//
// A packet of bad length goes from S_IDLE straight to S_DONE and from there to the result register.
// An accepted packet is compared against the stored entries one per cycle through the
// single read port of the identifier memory. A new identifier reaches the result register
// after S_SCAN has read every stored entry and S_WRITE has stored it, by way of S_DONE.
// A duplicate goes from S_SCAN to S_DONE as soon as its match is seen, and on to the result register.
// The block takes no new packet until the current one has moved to the result register.
// Reset clears the pointers and the fill count; the memory needs no clearing pass.
// A stalled result holds in its register while the next packet is already taken.
`default_nettype none

module identifier_dedup_ring_store
    import idrs_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    idrs_pkt_if.sink   pkt,
    idrs_res_if.source result
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_WRITE = 4'b0100,
        S_DONE  = 4'b1000
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic               pend_reg, pend_next;
    logic [ID_BITS-1:0] id_reg, id_next;
    status_t            status_reg, status_next;
    logic [PTR_W-1:0]   wp_reg, wp_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               out_valid_reg, out_valid_next;
    status_t            out_status_reg, out_status_next;
    logic [CNT_W-1:0]   out_fill_reg, out_fill_next;

    ram_req_t           ram_req;
    logic [ID_BITS-1:0] rd_data;
    logic               issue;
    logic               hit;

    idrs_ram u_ram (
        .clk     (clk),
        .req     (ram_req),
        .rd_data (rd_data)
    );

    assign pkt.ready         = (state_reg == S_IDLE);
    assign result.valid      = out_valid_reg;
    assign result.status     = out_status_reg;
    assign result.fill_level = out_fill_reg;

    assign issue = (idx_reg < count_reg);
    // Read data is registered in the memory, so it and any match appear in the cycle after the address.
    assign hit   = pend_reg && (rd_data == id_reg);

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        pend_next       = 1'b0;
        id_next         = id_reg;
        status_next     = status_reg;
        wp_next         = wp_reg;
        count_next      = count_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_fill_next   = out_fill_reg;

        ram_req.wr_en   = 1'b0;
        ram_req.wr_addr = wp_reg;
        ram_req.wr_data = id_reg;
        ram_req.rd_en   = 1'b0;
        ram_req.rd_addr = idx_reg[PTR_W-1:0];

        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (pkt.valid)
                begin
                    id_next  = ID_BITS'(pkt.ident);
                    idx_next = '0;
                    if (pkt.packet_length == LEN_OK)
                    begin
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        status_next = ST_BAD_LENGTH;
                        state_next  = S_DONE;
                    end
                end
            end
            S_SCAN:
            begin
                if (hit)
                begin
                    status_next = ST_DUPLICATE;
                    state_next  = S_DONE;
                end
                else if (issue)
                begin
                    ram_req.rd_en = 1'b1;
                    pend_next     = 1'b1;
                    idx_next      = idx_reg + CNT_W'(1);
                end
                else if (!pend_reg)
                begin
                    state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                ram_req.wr_en = 1'b1;
                wp_next       = (wp_reg == PTR_LAST) ? '0 : wp_reg + PTR_W'(1);
                if (count_reg != CNT_FULL)
                begin
                    count_next = count_reg + CNT_W'(1);
                end
                status_next = ST_STORED;
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_fill_next   = count_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pend_reg      <= 1'b0;
            wp_reg        <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            wp_reg        <= wp_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        id_reg         <= id_next;
        status_reg     <= status_next;
        out_status_reg <= out_status_next;
        out_fill_reg   <= out_fill_next;
    end

endmodule

`default_nettype wire

// ===== src/idrs_checker.sv =====
// Port-level checks for the identifier deduplicating ring store, and the bind that attaches them.
// Depends on idrs_pkg and on the top level's channel interfaces.
`default_nettype none

module idrs_checker
    import idrs_pkg::*;
(
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             pkt_valid,
    input wire logic             pkt_ready,
    input wire logic             res_valid,
    input wire logic             res_ready,
    input wire logic [1:0]       res_status,
    input wire logic [CNT_W-1:0] res_fill_level
);

    // A waiting result keeps its contents until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=>
            (res_valid && $stable(res_status) && $stable(res_fill_level)))
        else $error("result changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_status == ST_STORED || res_status == ST_DUPLICATE
                       || res_status == ST_BAD_LENGTH))
        else $error("result carries an undefined status code");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_fill_level <= CNT_FULL))
        else $error("fill level exceeds the store depth");

    // Each packet is worked on alone, so the input closes right after a transaction.
    assert property (@(posedge clk) disable iff (!rst_n)
        (pkt_valid && pkt_ready) |=> !pkt_ready)
        else $error("packet taken while the previous one is in work");

endmodule

bind identifier_dedup_ring_store idrs_checker u_idrs_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .pkt_valid      (pkt.valid),
    .pkt_ready      (pkt.ready),
    .res_valid      (result.valid),
    .res_ready      (result.ready),
    .res_status     (result.status),
    .res_fill_level (result.fill_level)
);

`default_nettype wire
